>>> rtl/core/tsr_pkg.sv
// shared constants and controller/datapath interface types of the span rasteriser
`default_nettype none
package tsr_pkg;

	// table depth and derived widths
	localparam int MAX_ROWS = 4096;
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);

	// fixed field widths
	localparam int COORD_W   = 28;
	localparam int FRAC_BITS = 16;
	localparam int ROW_W     = COORD_W - FRAC_BITS;
	localparam int COL_W     = 16;
	localparam int DATA_W    = 32;
	localparam int PITCH_W   = 16;
	localparam int QUOT_W    = COORD_W;
	localparam int STEP_W    = QUOT_W + 1;
	localparam int ACC_W     = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [ACC_W-1:0] HALF_PIXEL = 32'h0000_8000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH    = 1'b1;

	// item actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_SPAN = 1'b1;

	// edge order v0-v1, v1-v2, v2-v0
	localparam logic [1:0] EDGE_01 = 2'd0;
	localparam logic [1:0] EDGE_12 = 2'd1;
	localparam logic [1:0] EDGE_20 = 2'd2;

	typedef struct packed {
		logic load;
		logic set_edge;
		logic next_edge;
		logic take_step;
		logic row_step;
		logic span_read;
		logic span_out;
		logic ack_out;
	} dp_cmd_t;

	typedef struct packed {
		logic edge_flat;
		logic edge_last;
		logic div_done;
		logic rows_done;
		logic span_avail;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/tsr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module tsr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/tsr_div.sv
// bit-serial restoring divider for the edge slope
`default_nettype none
module tsr_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tsr_pkg::QUOT_W-1:0] dividend,
	input  wire logic [tsr_pkg::ROW_W-1:0]  divisor,
	output logic                            done,
	output logic      [tsr_pkg::QUOT_W-1:0] quotient
);
	import tsr_pkg::*;

	localparam int CW = $clog2(QUOT_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [QUOT_W-1:0] quo_q;
	logic [ROW_W-1:0]  rem_q;
	logic [ROW_W-1:0]  div_q;
	logic [ROW_W:0]    shifted;
	logic              fits;

	// one quotient bit per cycle
	assign shifted = {rem_q, quo_q[QUOT_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(QUOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QUOT_W-2:0], fits};
			if (fits) begin
				rem_q <= ROW_W'(shifted - {1'b0, div_q});
			end else begin
				rem_q <= shifted[ROW_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/core/tsr_datapath.sv
// edge setup, stepping, column tables and span output registers
`default_nettype none
module tsr_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tsr_pkg::dp_cmd_t              cmd,
	output tsr_pkg::dp_sts_t                   sts,
	input  wire logic                          cfg_write,
	input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsr_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_y,
	input  wire logic [tsr_pkg::DATA_W-1:0]    fill_color,
	output logic                               span_valid,
	output logic      [tsr_pkg::ROW_W-1:0]     row,
	output logic      [tsr_pkg::COL_W-1:0]     x_start,
	output logic      [tsr_pkg::COL_W-1:0]     x_end,
	output logic      [tsr_pkg::COL_W-1:0]     pixel_count,
	output logic      [tsr_pkg::DATA_W-1:0]    write_address,
	output logic      [tsr_pkg::DATA_W-1:0]    span_color,
	output logic                               last
);
	import tsr_pkg::*;

	logic [DATA_W-1:0]  base_q;
	logic [PITCH_W-1:0] pitch_q;

	logic [COORD_W-1:0] v0x_q, v0y_q, v1x_q, v1y_q, v2x_q, v2y_q;
	logic [DATA_W-1:0]  color_q;
	logic [ROW_W-1:0]   top_q;
	logic [CNT_W-1:0]   total_q;
	logic [CNT_W-1:0]   emitted_q;
	logic [1:0]         edge_q;

	logic [COORD_W-1:0] ax, ay, bx, by, sx, sy, ex, ey;
	logic [COORD_W-1:0] lo, hi, dy_full, dx_mag;
	logic [ROW_W-1:0]   height;
	logic               is_left, dx_neg;

	logic [ACC_W-1:0]   acc_q;
	logic [STEP_W-1:0]  step_q;
	logic [ROW_W-1:0]   r_q, er_q;
	logic               left_q, neg_q, dyz_q;

	logic               div_done;
	logic [QUOT_W-1:0]  quo;

	logic [ROW_W-1:0]   tidx;
	logic               tidx_ok;
	logic               we_left, we_right;
	logic [COL_W-1:0]   left_rd, right_rd;
	logic [ROW_W-1:0]   row_now, row_s1;
	logic [PITCH_W+ROW_W-1:0] prod_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pitch_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SURFACE_BASE: base_q  <= cfg_data;
				CFG_ROW_PITCH:    pitch_q <= cfg_data[PITCH_W-1:0];
				default:          ;
			endcase
		end
	end

	// top and bottom rows of the incoming triangle
	always_comb begin
		lo = v0_y;
		hi = v0_y;
		if (v1_y < lo) lo = v1_y;
		if (v2_y < lo) lo = v2_y;
		if (v1_y > hi) hi = v1_y;
		if (v2_y > hi) hi = v2_y;
		height = hi[COORD_W-1:FRAC_BITS] - lo[COORD_W-1:FRAC_BITS];
	end

	// triangle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			total_q   <= '0;
			emitted_q <= '0;
			color_q   <= '0;
			edge_q    <= EDGE_01;
		end else if (cmd.load) begin
			top_q     <= lo[COORD_W-1:FRAC_BITS];
			total_q   <= ((ROW_W+1)'(height) > (ROW_W+1)'(MAX_ROWS)) ?
				CNT_W'(MAX_ROWS) : CNT_W'(height);
			emitted_q <= '0;
			color_q   <= fill_color;
			edge_q    <= EDGE_01;
		end else begin
			if (cmd.next_edge) edge_q <= edge_q + 2'd1;
			if (cmd.span_out) emitted_q <= emitted_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v0x_q <= v0_x; v0y_q <= v0_y;
			v1x_q <= v1_x; v1y_q <= v1_y;
			v2x_q <= v2_x; v2y_q <= v2_y;
		end
	end

	// current edge endpoints, upper one first
	always_comb begin
		unique case (edge_q)
			EDGE_01: begin ax = v0x_q; ay = v0y_q; bx = v1x_q; by = v1y_q; end
			EDGE_12: begin ax = v1x_q; ay = v1y_q; bx = v2x_q; by = v2y_q; end
			default: begin ax = v2x_q; ay = v2y_q; bx = v0x_q; by = v0y_q; end
		endcase
		is_left = ay < by;
		sx      = is_left ? ax : bx;
		sy      = is_left ? ay : by;
		ex      = is_left ? bx : ax;
		ey      = is_left ? by : ay;
		dy_full = ey - sy;
		dx_neg  = ex < sx;
		dx_mag  = dx_neg ? (sx - ex) : (ex - sx);
	end

	tsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.set_edge),
		.dividend (dx_mag),
		.divisor  (dy_full[COORD_W-1:FRAC_BITS]),
		.done     (div_done),
		.quotient (quo)
	);

	// edge accumulator and row counter
	always_ff @(posedge clk) begin
		if (cmd.set_edge) begin
			acc_q  <= ACC_W'(sx) + HALF_PIXEL;
			r_q    <= sy[COORD_W-1:FRAC_BITS];
			er_q   <= ey[COORD_W-1:FRAC_BITS];
			left_q <= is_left;
			neg_q  <= dx_neg;
			dyz_q  <= dy_full[COORD_W-1:FRAC_BITS] == '0;
		end
		if (cmd.take_step) begin
			if (dyz_q) begin
				step_q <= '0;
			end else if (neg_q) begin
				step_q <= STEP_W'(0) - {1'b0, quo};
			end else begin
				step_q <= {1'b0, quo};
			end
		end
		if (cmd.row_step) begin
			acc_q <= acc_q + {{(ACC_W-STEP_W){step_q[STEP_W-1]}}, step_q};
			r_q   <= r_q + 1'b1;
		end
	end

	// table writes, dropped beyond the table depth
	assign tidx     = r_q - top_q;
	assign tidx_ok  = {1'b0, tidx} < (ROW_W+1)'(MAX_ROWS);
	assign we_left  = cmd.row_step && left_q && tidx_ok;
	assign we_right = cmd.row_step && !left_q && tidx_ok;

	tsr_ram #(.WIDTH(COL_W), .DEPTH(MAX_ROWS)) u_left (
		.clk   (clk),
		.we    (we_left),
		.waddr (tidx[ROW_AW-1:0]),
		.wdata (acc_q[FRAC_BITS+COL_W-1:FRAC_BITS]),
		.raddr (emitted_q[ROW_AW-1:0]),
		.rdata (left_rd)
	);

	tsr_ram #(.WIDTH(COL_W), .DEPTH(MAX_ROWS)) u_right (
		.clk   (clk),
		.we    (we_right),
		.waddr (tidx[ROW_AW-1:0]),
		.wdata (acc_q[FRAC_BITS+COL_W-1:FRAC_BITS]),
		.raddr (emitted_q[ROW_AW-1:0]),
		.rdata (right_rd)
	);

	// row offset product while the tables are read
	assign row_now = top_q + ROW_W'(emitted_q);

	always_ff @(posedge clk) begin
		if (cmd.span_read) begin
			row_s1  <= row_now;
			prod_s1 <= pitch_q * row_now;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid    <= 1'b0;
			row           <= '0;
			x_start       <= '0;
			x_end         <= '0;
			pixel_count   <= '0;
			write_address <= '0;
			span_color    <= '0;
			last          <= 1'b0;
		end else if (cmd.span_out) begin
			span_valid    <= 1'b1;
			row           <= row_s1;
			x_start       <= left_rd;
			x_end         <= right_rd;
			pixel_count   <= (left_rd < right_rd) ? (right_rd - left_rd) : '0;
			write_address <= base_q + DATA_W'(prod_s1) + DATA_W'({left_rd, 2'b00});
			span_color    <= color_q;
			last          <= (emitted_q + 1'b1) == total_q;
		end else if (cmd.ack_out) begin
			span_valid    <= 1'b0;
			row           <= '0;
			x_start       <= '0;
			x_end         <= '0;
			pixel_count   <= '0;
			write_address <= '0;
			span_color    <= '0;
			last          <= 1'b0;
		end
	end

	// status to the controller
	assign sts.edge_flat  = ay == by;
	assign sts.edge_last  = edge_q == EDGE_20;
	assign sts.div_done   = div_done;
	assign sts.rows_done  = !(r_q < er_q);
	assign sts.span_avail = (emitted_q < total_q) && (emitted_q < CNT_W'(MAX_ROWS));

endmodule
`default_nettype wire

>>> rtl/core/tsr_ctrl.sv
// sequencing state machine for triangle loads and span requests
`default_nettype none
module tsr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             action,
	input  wire tsr_pkg::dp_sts_t sts,
	output tsr_pkg::dp_cmd_t      cmd,
	output logic                  busy,
	output logic                  done
);
	import tsr_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_EDGE     = 7'b0000010,
		S_DIV      = 7'b0000100,
		S_ROWS     = 7'b0001000,
		S_ACK      = 7'b0010000,
		S_SPAN_RD  = 7'b0100000,
		S_SPAN_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q, done_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == ACT_LOAD) begin
						cmd.load = 1'b1;
						state_d  = S_EDGE;
					end else if (sts.span_avail) begin
						state_d = S_SPAN_RD;
					end else begin
						state_d = S_ACK;
					end
				end
			end
			S_EDGE: begin
				if (!sts.edge_flat) begin
					cmd.set_edge = 1'b1;
					state_d      = S_DIV;
				end else if (sts.edge_last) begin
					state_d = S_ACK;
				end else begin
					cmd.next_edge = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.take_step = 1'b1;
					state_d       = S_ROWS;
				end
			end
			S_ROWS: begin
				if (!sts.rows_done) begin
					cmd.row_step = 1'b1;
				end else if (sts.edge_last) begin
					state_d = S_ACK;
				end else begin
					cmd.next_edge = 1'b1;
					state_d       = S_EDGE;
				end
			end
			S_ACK: begin
				cmd.ack_out = 1'b1;
				done_d      = 1'b1;
				state_d     = S_IDLE;
			end
			S_SPAN_RD: begin
				cmd.span_read = 1'b1;
				state_d       = S_SPAN_OUT;
			end
			S_SPAN_OUT: begin
				cmd.span_out = 1'b1;
				done_d       = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	// one strobe per item, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item left block idle");

	a_div_to_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && sts.div_done) |=> state_q == S_ROWS)
		else $error("slope ready but edge stepping not started");

endmodule
`default_nettype wire

>>> rtl/core/triangle_span_rasterizer.sv
// top level of the scanline triangle span rasteriser
//
// A load item (action 0) finds the top and bottom rows and steps each sloped
// edge into the left or right column table: per sloped edge a setup step, the
// bit-serial slope divider and a step for each row, and for each horizontal
// edge a skip to the next. Both tables get one row per triangle row. A span
// item (action 1) does a table read with the row product, then the address
// sum into the result registers. A span request with nothing pending is
// answered with span_valid low. The result appears for one cycle with done
// in the same cycle that busy falls, and the receiver cannot hold it off.
// Result fields hold until the next result. The column tables are not
// cleared after reset.
`default_nettype none
module triangle_span_rasterizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	output logic                               done,
	input  wire logic                          cfg_write,
	input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsr_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic                          action,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_y,
	input  wire logic [tsr_pkg::DATA_W-1:0]    fill_color,
	output logic                               span_valid,
	output logic      [tsr_pkg::ROW_W-1:0]     row,
	output logic      [tsr_pkg::COL_W-1:0]     x_start,
	output logic      [tsr_pkg::COL_W-1:0]     x_end,
	output logic      [tsr_pkg::COL_W-1:0]     pixel_count,
	output logic      [tsr_pkg::DATA_W-1:0]    write_address,
	output logic      [tsr_pkg::DATA_W-1:0]    span_color,
	output logic                               last
);
	import tsr_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer
	tsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic, tables and result registers
	tsr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.v0_x          (v0_x),
		.v0_y          (v0_y),
		.v1_x          (v1_x),
		.v1_y          (v1_y),
		.v2_x          (v2_x),
		.v2_y          (v2_y),
		.fill_color    (fill_color),
		.span_valid    (span_valid),
		.row           (row),
		.x_start       (x_start),
		.x_end         (x_end),
		.pixel_count   (pixel_count),
		.write_address (write_address),
		.span_color    (span_color),
		.last          (last)
	);

endmodule
`default_nettype wire

>>> test/span_checker.sv
// span rasteriser checker: edge-table prediction and comparison of every result
module span_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          busy,
	input  wire logic                          done,
	input  wire logic                          cfg_write,
	input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tsr_pkg::DATA_W-1:0]    cfg_data,
	input  wire logic                          action,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v0_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v1_y,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_x,
	input  wire logic [tsr_pkg::COORD_W-1:0]   v2_y,
	input  wire logic [tsr_pkg::DATA_W-1:0]    fill_color,
	input  wire logic                          span_valid,
	input  wire logic [tsr_pkg::ROW_W-1:0]     row,
	input  wire logic [tsr_pkg::COL_W-1:0]     x_start,
	input  wire logic [tsr_pkg::COL_W-1:0]     x_end,
	input  wire logic [tsr_pkg::COL_W-1:0]     pixel_count,
	input  wire logic [tsr_pkg::DATA_W-1:0]    write_address,
	input  wire logic [tsr_pkg::DATA_W-1:0]    span_color,
	input  wire logic                          last,
	output int                                 errors,
	output int                                 pending
);
	import tsr_pkg::*;

	typedef struct packed {
		logic              valid;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  xs;
		logic [COL_W-1:0]  xe;
		logic [COL_W-1:0]  count;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] color;
		logic              last;
	} span_t;

	span_t              span_queue[$];
	logic [COL_W-1:0]   left_cols[MAX_ROWS];
	logic [COL_W-1:0]   right_cols[MAX_ROWS];
	logic [DATA_W-1:0]  base_reg;
	logic [PITCH_W-1:0] pitch_reg;
	logic [ROW_W-1:0]   first_row;
	int unsigned        row_total;
	int unsigned        row_done;
	logic [DATA_W-1:0]  color_reg;
	int                 mismatches;

	assign pending = span_queue.size();

	// step one edge into the left table (going down) or right table (going up)
	task automatic step_edge(input logic [COORD_W-1:0] ax, ay, bx, by,
			input int unsigned top);
		logic           down;
		logic [COORD_W-1:0] sx, sy, ex, ey;
		int unsigned    sr, er, dy, r, idx;
		longint         dx, stp, acc;
		down = ay < by;
		if (down) begin
			sx = ax; sy = ay; ex = bx; ey = by;
		end else begin
			sx = bx; sy = by; ex = ax; ey = ay;
		end
		sr = sy >> FRAC_BITS;
		er = ey >> FRAC_BITS;
		dy = (ey - sy) >> FRAC_BITS;
		dx = longint'({36'd0, ex}) - longint'({36'd0, sx});
		stp = (dy != 0) ? dx / longint'(dy) : 64'sd0;
		acc = longint'({36'd0, sx}) + 64'sh8000;
		for (r = sr; r < er; r++) begin
			idx = r - top;
			if (idx < MAX_ROWS) begin
				if (down)
					left_cols[idx] = acc[31:16];
				else
					right_cols[idx] = acc[31:16];
			end
			acc += stp;
		end
	endtask

	// predict the result of one accepted span request
	function automatic span_t next_span();
		span_t          s;
		int unsigned    idx;
		logic [COL_W-1:0] st, en;
		s = '0;
		if (row_done < row_total && row_done < MAX_ROWS) begin
			idx = row_done;
			st = left_cols[idx];
			en = right_cols[idx];
			s.valid = 1'b1;
			s.row = first_row + idx[ROW_W-1:0];
			s.xs = st;
			s.xe = en;
			s.count = (st < en) ? en - st : '0;
			s.addr = base_reg + DATA_W'(pitch_reg) * DATA_W'(s.row) + 32'd4 * DATA_W'(st);
			s.color = color_reg;
			s.last = (idx + 1 == row_total);
			row_done = idx + 1;
		end
		return s;
	endfunction

	task automatic load_triangle();
		logic [COORD_W-1:0] lo, hi;
		int unsigned        top, height;
		lo = v0_y; hi = v0_y;
		if (v1_y < lo) lo = v1_y;
		if (v2_y < lo) lo = v2_y;
		if (v1_y > hi) hi = v1_y;
		if (v2_y > hi) hi = v2_y;
		top = lo >> FRAC_BITS;
		height = (hi >> FRAC_BITS) - top;
		if (v0_y != v1_y) step_edge(v0_x, v0_y, v1_x, v1_y, top);
		if (v1_y != v2_y) step_edge(v1_x, v1_y, v2_x, v2_y, top);
		if (v2_y != v0_y) step_edge(v2_x, v2_y, v0_x, v0_y, top);
		first_row = top[ROW_W-1:0];
		row_total = (height > MAX_ROWS) ? MAX_ROWS : height;
		row_done = 0;
		color_reg = fill_color;
	endtask

	// watch writes, items and results
	always @(posedge clk or negedge arst_n) begin
		span_t exp_s, got;
		if (!arst_n) begin
			span_queue.delete();
			base_reg = '0;
			pitch_reg = '0;
			first_row = '0;
			row_total = 0;
			row_done = 0;
			color_reg = '0;
			errors = 0;
			mismatches = 0;
		end else begin
			if (done) begin
				got = '{span_valid, row, x_start, x_end, pixel_count, write_address,
					span_color, last};
				if (span_queue.size() == 0) begin
					errors++;
					$display("unexpected result %h", got);
				end else begin
					exp_s = span_queue.pop_front();
					if (got !== exp_s) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: valid %b/%b row %0d/%0d xs %h/%h xe %h/%h cnt %h/%h addr %h/%h color %h/%h last %b/%b",
								exp_s.valid, got.valid, exp_s.row, got.row, exp_s.xs, got.xs,
								exp_s.xe, got.xe, exp_s.count, got.count, exp_s.addr, got.addr,
								exp_s.color, got.color, exp_s.last, got.last);
					end
				end
			end
			if (cfg_write) begin
				if (cfg_index == CFG_SURFACE_BASE)
					base_reg = cfg_data;
				else if (cfg_index == CFG_ROW_PITCH)
					pitch_reg = cfg_data[PITCH_W-1:0];
			end
			if (start && !busy) begin
				if (action == ACT_LOAD) begin
					load_triangle();
					span_queue.push_back('0);
				end else
					span_queue.push_back(next_span());
			end
		end
	end
endmodule

>>> test/testbench.sv
// testbench top: stimulus for the span rasteriser and the final verdict
module testbench;
	import tsr_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]  cfg_data = '0;
	logic               action = ACT_SPAN;
	logic [COORD_W-1:0] v0_x = '0, v0_y = '0, v1_x = '0, v1_y = '0, v2_x = '0, v2_y = '0;
	logic [DATA_W-1:0]  fill_color = '0;
	wire                busy, done, span_valid, last;
	wire  [ROW_W-1:0]   row;
	wire  [COL_W-1:0]   x_start, x_end, pixel_count;
	wire  [DATA_W-1:0]  write_address, span_color;
	int                 errors, pending;
	int                 items_sent = 0;
	int                 loads_sent = 0;
	int                 spans_sent = 0;
	int                 gap_pct = 11;

	always #1 clk = ~clk;

	triangle_span_rasterizer DUT (.*);
	span_checker checker_i (.*);

	// hold-off limit
	initial begin
		#80000000;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		start <= 1'b0;
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// present one item and hold it until taken, with random gaps first
	task automatic send(input logic act, input logic [COORD_W-1:0] ax, ay, bx, by, cx, cy,
			input logic [DATA_W-1:0] col);
		int n;
		if ($urandom_range(99) < gap_pct) begin
			n = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		v0_x <= ax; v0_y <= ay; v1_x <= bx; v1_y <= by; v2_x <= cx; v2_y <= cy;
		fill_color <= col;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		items_sent++;
		if (act == ACT_LOAD) loads_sent++; else spans_sent++;
	endtask

	task automatic span_req();
		send(ACT_SPAN, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), $urandom);
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		start <= 1'b0;
		forever begin
			@(negedge clk);
			if (pending == 0 && !busy) break;
		end
		repeat (8) @(posedge clk);
	endtask

	// random triangle, mostly short, sometimes tall; returns its row height
	task automatic random_triangle(output int h);
		logic [COORD_W-1:0] ys[3];
		logic [COORD_W-1:0] t, ymin, ymax;
		int unsigned        rng, lo, sel, j;
		sel = $urandom_range(99);
		rng = (sel < 85) ? $urandom_range(0, 24) : (sel < 97) ? $urandom_range(25, 300)
			: $urandom_range(301, 4095);
		rng = rng * 65536 + $urandom_range(0, 65535);
		if (rng > 32'h0FFF_FFFF) rng = 32'h0FFF_FFFF;
		lo = $urandom_range(0, 32'h0FFF_FFFF - rng);
		ys[0] = COORD_W'(lo);
		ys[1] = COORD_W'(lo + $urandom_range(0, rng));
		ys[2] = COORD_W'(lo + rng);
		// horizontal edge or sub-pixel edge now and then
		sel = $urandom_range(9);
		if (sel == 0) ys[1] = ys[0];
		else if (sel == 1) ys[1] = ys[0] + COORD_W'($urandom_range(1, 65535));
		// random vertex order
		for (int i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = ys[i];
			ys[i] = ys[j];
			ys[j] = t;
		end
		ymin = ys[0];
		ymax = ys[0];
		for (int i = 1; i < 3; i++) begin
			if (ys[i] < ymin) ymin = ys[i];
			if (ys[i] > ymax) ymax = ys[i];
		end
		h = int'(ymax >> 16) - int'(ymin >> 16);
		send(ACT_LOAD, COORD_W'($urandom), ys[0], COORD_W'($urandom), ys[1],
			COORD_W'($urandom), ys[2], $urandom);
	endtask

	task automatic random_phase(input int n_items);
		int h, k, goal;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(19) == 0)
				span_req();
			else begin
				random_triangle(h);
				k = (h > 40) ? $urandom_range(1, 30) : h + $urandom_range(0, 3);
				if ($urandom_range(9) == 0 && k > 1) k = $urandom_range(0, k - 1);
				repeat (k) span_req();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme registers, spans with nothing loaded, empty triangle
		write_reg(CFG_SURFACE_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_ROW_PITCH, 32'h0000_FFFF);
		span_req();
		send(ACT_LOAD, '0, '0, '0, '0, '0, '0, '0);
		span_req();
		// full-height triangle over the whole coordinate range
		send(ACT_LOAD, 28'h800_0000, '0, '0, 28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF,
			32'hFFFF_FFFF);
		repeat (6) span_req();
		// sub-pixel edge heights give a zero step
		send(ACT_LOAD, 28'h001_0000, 28'h001_0000, 28'h005_0000, 28'h001_FFFF,
			28'h003_0000, 28'h004_8000, 32'h1234_5678);
		repeat (5) span_req();
		// horizontal top edge, clockwise order, and a flat triangle
		send(ACT_LOAD, 28'h00A_0000, 28'h002_0000, 28'h002_0000, 28'h002_0000,
			28'h006_0000, 28'h007_0000, 32'hA5A5_5A5A);
		repeat (6) span_req();
		send(ACT_LOAD, 28'h010_0000, 28'h003_4000, 28'hFFF_0000, 28'h003_4000,
			28'h000_0000, 28'h003_4000, 32'h0);
		span_req();
		drain();

		write_reg(CFG_SURFACE_BASE, 32'h0);
		write_reg(CFG_ROW_PITCH, 32'h0);
		random_phase(220);
		drain();
		write_reg(CFG_SURFACE_BASE, $urandom);
		write_reg(CFG_ROW_PITCH, $urandom_range(0, 65535));
		gap_pct = 0;
		random_phase(220);
		gap_pct = 11;
		drain();
		write_reg(CFG_SURFACE_BASE, 32'h8000_0000);
		write_reg(CFG_ROW_PITCH, 32'd2560);
		random_phase(230);
		drain();
		write_reg(CFG_SURFACE_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_ROW_PITCH, 32'hFFFF);
		random_phase(230);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d items: %0d triangle loads and %0d span requests",
			items_sent, loads_sent, spans_sent);
		$display("register settings from zero to all ones, gaps and a gap-free phase");
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
